@@ hw/rtl/mlfq_pkg.sv @@
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants for the three-level feedback queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package mlfq_pkg;

    localparam int PROCESS_SLOTS = 64;

    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_PICK = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [1:0] CAUSE_NEW  = 2'd0;
    localparam logic [1:0] CAUSE_IO   = 2'd1;
    localparam logic [1:0] CAUSE_PREE = 2'd2;
    localparam logic [1:0] CAUSE_KEEP = 2'd3;

    localparam logic [1:0] REG_BOOST = 2'd0;
    localparam logic [1:0] REG_Q0    = 2'd1;
    localparam logic [1:0] REG_Q1    = 2'd2;
    localparam logic [1:0] REG_Q2    = 2'd3;

    localparam logic [15:0] BOOST_RESET = 16'd20;
    localparam logic [7:0]  QUANT0_RESET = 8'd2;
    localparam logic [7:0]  QUANT1_RESET = 8'd4;
    localparam logic [7:0]  QUANT2_RESET = 8'd8;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  proc_id;
        logic [1:0]  enqueue_cause;
        logic [31:0] tick_time;
    } in_item_t;

    typedef struct packed {
        logic       dispatch_valid;
        logic [5:0] dispatch_pid;
        logic [1:0] dispatch_level;
        logic [7:0] dispatch_quantum;
        logic       boost_done;
        logic [6:0] boosted_count;
        logic       push_dropped;
        logic [6:0] depth_level0;
        logic [6:0] depth_level1;
        logic [6:0] depth_level2;
    } out_item_t;

    typedef struct packed {
        logic [15:0] boost_period;
        logic [7:0]  quantum0;
        logic [7:0]  quantum1;
        logic [7:0]  quantum2;
    } cfg_t;

endpackage
`default_nettype wire

@@ hw/rtl/mlfq_regs.sv @@
// ----------------------------------------------------------------------------
// mlfq_regs
// APB-style configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none
module mlfq_regs
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output mlfq_pkg::cfg_t     cfg
);
    mlfq_pkg::cfg_t cfg_reg;
    logic           wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.boost_period   <= mlfq_pkg::BOOST_RESET;
            cfg_reg.quantum0       <= mlfq_pkg::QUANT0_RESET;
            cfg_reg.quantum1       <= mlfq_pkg::QUANT1_RESET;
            cfg_reg.quantum2       <= mlfq_pkg::QUANT2_RESET;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                mlfq_pkg::REG_BOOST: cfg_reg.boost_period <= pwdata[15:0];
                mlfq_pkg::REG_Q0:    cfg_reg.quantum0 <= pwdata[7:0];
                mlfq_pkg::REG_Q1:    cfg_reg.quantum1 <= pwdata[7:0];
                mlfq_pkg::REG_Q2:    cfg_reg.quantum2 <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            mlfq_pkg::REG_BOOST: prdata = {16'd0, cfg_reg.boost_period};
            mlfq_pkg::REG_Q0:    prdata = {24'd0, cfg_reg.quantum0};
            mlfq_pkg::REG_Q1:    prdata = {24'd0, cfg_reg.quantum1};
            mlfq_pkg::REG_Q2:    prdata = {24'd0, cfg_reg.quantum2};
            default:             prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/mlfq_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// mlfq_scheduler_top
// Three-level feedback queue scheduler with memory-held ready queues.
// ----------------------------------------------------------------------------
// Enqueue, tick without boost and no-op pass through the level and done states; pick
// adds one queue RAM read, skipped when every queue is empty.
// Boost: each moved entry is a read then a write of the RAM.
// One transaction in flight; the next is accepted as the result is taken.
// Reset clears counts, boost time and level valid bits; queue RAM is not cleared.
`default_nettype none
module mlfq_scheduler_top
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire mlfq_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output mlfq_pkg::out_item_t      out_data
);
    localparam int SW = $clog2(mlfq_pkg::PROCESS_SLOTS);
    localparam int CW = $clog2(mlfq_pkg::PROCESS_SLOTS + 1);
    localparam int AW = SW + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LVL   = 3'd1;
    localparam logic [2:0] S_PICK  = 3'd2;
    localparam logic [2:0] S_BRD   = 3'd3;
    localparam logic [2:0] S_BWR   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    mlfq_pkg::cfg_t cfg;

    mlfq_regs u_regs
    (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    // queue RAM: circular buffers, one region per level
    logic [5:0]    qram [0:3*mlfq_pkg::PROCESS_SLOTS-1];
    logic [1:0]    lram [0:mlfq_pkg::PROCESS_SLOTS-1];
    logic [mlfq_pkg::PROCESS_SLOTS-1:0] lvalid_reg;

    logic [2:0]    state_reg;
    mlfq_pkg::in_item_t item_reg;
    logic [CW-1:0] cnt_reg  [0:2];
    logic [SW-1:0] head_reg [0:2];
    logic [31:0]   last_reg;
    logic [6:0]    moved_reg;
    logic [1:0]    blv_reg;
    logic          out_valid_reg;
    mlfq_pkg::out_item_t out_reg;

    logic [5:0]    qrd;
    logic [1:0]    lrd;
    logic          q_re, q_we, l_we;
    logic [AW-1:0] q_ra, q_wa;
    logic [5:0]    q_wd;
    logic [SW-1:0] l_wa;
    logic [1:0]    l_wd;
    logic          accept;

    always_ff @(posedge clk)
    begin
        if (q_we)
            qram[q_wa] <= q_wd;
        if (q_re)
            qrd <= qram[q_ra];
        if (l_we)
            lram[l_wa] <= l_wd;
        if (accept)
            lrd <= lram[in_data.proc_id[SW-1:0]];
    end

    function automatic logic [AW-1:0] qaddr(input logic [1:0] lv,
                                            input logic [SW-1:0] idx);
        logic [AW-1:0] a;
        a = AW'(lv) * AW'(mlfq_pkg::PROCESS_SLOTS) + AW'(idx);
        return a;
    endfunction

    function automatic logic [SW-1:0] wrap(input logic [SW-1:0] h,
                                           input logic [CW-1:0] n);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(n);
        if (s >= (CW+1)'(mlfq_pkg::PROCESS_SLOTS))
            s = s - (CW+1)'(mlfq_pkg::PROCESS_SLOTS);
        return s[SW-1:0];
    endfunction

    logic          full0;
    logic [1:0]    curlv, newlv, picklv;
    logic          anyq, do_boost;
    logic [31:0]   diff;
    mlfq_pkg::out_item_t out_next;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign full0     = cnt_reg[0] == CW'(mlfq_pkg::PROCESS_SLOTS);
    assign curlv     = lvalid_reg[item_reg.proc_id[SW-1:0]] ? lrd : 2'd0;
    assign diff      = item_reg.tick_time - last_reg;
    assign do_boost  = item_reg.tick_time != 32'd0 && item_reg.tick_time >= last_reg
                       && diff >= {16'd0, cfg.boost_period};

    always_comb
    begin
        case (item_reg.enqueue_cause)
            mlfq_pkg::CAUSE_NEW:  newlv = 2'd0;
            mlfq_pkg::CAUSE_IO:   newlv = (curlv == 2'd0) ? 2'd0 : curlv - 2'd1;
            mlfq_pkg::CAUSE_PREE: newlv = (curlv >= 2'd2) ? 2'd2 : curlv + 2'd1;
            default:              newlv = curlv;
        endcase
        anyq = 1'b1;
        if (cnt_reg[0] != '0)
            picklv = 2'd0;
        else if (cnt_reg[1] != '0)
            picklv = 2'd1;
        else if (cnt_reg[2] != '0)
            picklv = 2'd2;
        else
        begin
            picklv = 2'd0;
            anyq = 1'b0;
        end
    end

    always_comb
    begin
        out_next = '0;
        case (item_reg.opcode)
            mlfq_pkg::OP_ENQ:
                out_next.push_dropped = cnt_reg[newlv] == CW'(mlfq_pkg::PROCESS_SLOTS);
            mlfq_pkg::OP_PICK:
            begin
                out_next.dispatch_valid = anyq;
                if (anyq)
                begin
                    out_next.dispatch_level = picklv;
                    case (picklv)
                        2'd0:    out_next.dispatch_quantum = cfg.quantum0;
                        2'd1:    out_next.dispatch_quantum = cfg.quantum1;
                        default: out_next.dispatch_quantum = cfg.quantum2;
                    endcase
                end
            end
            mlfq_pkg::OP_TICK:
                out_next.boost_done = do_boost;
            default: ;
        endcase
    end

    always_comb
    begin
        q_re = 1'b0;
        q_ra = qaddr(picklv, head_reg[picklv]);
        q_we = 1'b0;
        q_wa = qaddr(newlv, wrap(head_reg[newlv], cnt_reg[newlv]));
        q_wd = item_reg.proc_id;
        l_we = 1'b0;
        l_wa = item_reg.proc_id[SW-1:0];
        l_wd = newlv;
        case (state_reg)
            S_LVL:
            begin
                if (item_reg.opcode == mlfq_pkg::OP_ENQ)
                begin
                    l_we = 1'b1;
                    q_we = cnt_reg[newlv] != CW'(mlfq_pkg::PROCESS_SLOTS);
                end
                else if (item_reg.opcode == mlfq_pkg::OP_PICK)
                    q_re = anyq;
            end
            S_BRD:
            begin
                q_re = 1'b1;
                q_ra = qaddr(blv_reg, head_reg[blv_reg]);
            end
            S_BWR:
            begin
                l_we = 1'b1;
                l_wa = qrd[SW-1:0];
                l_wd = 2'd0;
                q_we = !full0;
                q_wa = qaddr(2'd0, wrap(head_reg[0], cnt_reg[0]));
                q_wd = qrd;
            end
            default: ;
        endcase
    end

    logic [SW-1:0] hnext;
    assign hnext = wrap(head_reg[blv_reg], CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            item_reg      <= '0;
            out_reg       <= '0;
            last_reg      <= '0;
            lvalid_reg    <= '0;
            moved_reg     <= '0;
            blv_reg       <= 2'd1;
            for (int i = 0; i < 3; i++)
            begin
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == S_DONE)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (l_we)
                lvalid_reg[l_wa] <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg  <= in_data;
                        state_reg <= S_LVL;
                    end
                end
                S_LVL:
                begin
                    out_reg <= out_next;
                    moved_reg <= '0;
                    blv_reg <= 2'd1;
                    state_reg <= S_DONE;
                    case (item_reg.opcode)
                        mlfq_pkg::OP_ENQ:
                        begin
                            if (cnt_reg[newlv] != CW'(mlfq_pkg::PROCESS_SLOTS))
                                cnt_reg[newlv] <= cnt_reg[newlv] + CW'(1);
                        end
                        mlfq_pkg::OP_PICK:
                        begin
                            if (anyq)
                            begin
                                cnt_reg[picklv]  <= cnt_reg[picklv] - CW'(1);
                                head_reg[picklv] <= wrap(head_reg[picklv], CW'(1));
                                state_reg <= S_PICK;
                            end
                        end
                        mlfq_pkg::OP_TICK:
                        begin
                            if (do_boost)
                            begin
                                last_reg <= item_reg.tick_time;
                                state_reg <= S_BRD;
                            end
                        end
                        default: ;
                    endcase
                end
                S_PICK:
                begin
                    out_reg.dispatch_pid <= qrd;
                    state_reg <= S_DONE;
                end
                S_BRD:
                begin
                    if (cnt_reg[blv_reg] == '0)
                    begin
                        if (blv_reg == 2'd2)
                            state_reg <= S_DONE;
                        else
                            blv_reg <= 2'd2;
                    end
                    else
                    begin
                        cnt_reg[blv_reg]  <= cnt_reg[blv_reg] - CW'(1);
                        head_reg[blv_reg] <= hnext;
                        state_reg <= S_BWR;
                    end
                end
                S_BWR:
                begin
                    if (!full0)
                        cnt_reg[0] <= cnt_reg[0] + CW'(1);
                    if (moved_reg != 7'd127)
                        moved_reg <= moved_reg + 7'd1;
                    state_reg <= S_BRD;
                end
                S_DONE:
                begin
                    if (item_reg.opcode == mlfq_pkg::OP_TICK)
                        out_reg.boosted_count <= moved_reg;
                    out_reg.depth_level0 <= 7'(cnt_reg[0]);
                    out_reg.depth_level1 <= 7'(cnt_reg[1]);
                    out_reg.depth_level2 <= 7'(cnt_reg[2]);
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !accept) else $error("accept while busy");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CW'(mlfq_pkg::PROCESS_SLOTS)) else $error("queue 0 overflow");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid) else $error("result lost");
`endif
endmodule
`default_nettype wire
